// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the ordered list block.
// Needs no package; clock, reset and expressions are passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/olar_pkg.sv =====
// Package for the ordered list block: sizes, opcodes, status codes and the
// item and internal structs. No dependencies.
`default_nettype none

package olar_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ECNT_W   = 5;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef logic signed [DATA_W-1:0] data_t;

  // Opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  // Status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NOTFOUND = 2'd1;
  localparam logic [1:0] STS_EMPTY    = 2'd2;
  localparam logic [1:0] STS_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    data_t      value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    data_t             entry_value;
    data_t             first_value;
    data_t             last_value;
    logic [ECNT_W-1:0] entry_count;
    logic              last_of_run;
  } out_item_t;

  // Request to the entry memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    data_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  // Result offered by the sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

  // Sequencer status
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } seq_stat_t;

  // Occupancy to the count field, masked or extended to its width
  function automatic logic [ECNT_W-1:0] count_field(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+ECNT_W-1:0] w;
    w = {{ECNT_W{1'b0}}, cnt};
    return w[ECNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/olar_if.sv =====
// Valid/ready channel interfaces for the request and result sides.
// Depends on olar_pkg.
`default_nettype none

interface olar_in_if;
  import olar_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

interface olar_out_if;
  import olar_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== sv/olar_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data
// that holds while no read is issued. No dependencies.
`default_nettype none

module olar_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/olar_seq.sv =====
// Sequencer of the ordered list: decodes requests, walks the entry memory
// for search, shift and listing, and keeps count, head and tail.
// Depends on olar_pkg and olar_if.
`default_nettype none

module olar_seq (
  input  logic                  clk,
  input  logic                  rst,
  olar_in_if.sink               req,
  input  olar_pkg::data_t       rdata,
  input  logic                  slot_free,
  output olar_pkg::ram_req_t    ram_req,
  output olar_pkg::emit_t       emit,
  output olar_pkg::seq_stat_t   stat
);
  import olar_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_LIST   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] occ, occ_next;
  logic [CNT_W-1:0] idx, idx_next;
  data_t            head, head_next;
  data_t            tail, tail_next;
  data_t            prev, prev_next;
  data_t            key, key_next;
  logic [1:0]       res_status, res_status_next;

  logic [CNT_W-1:0] occ_m1, idx_p1, idx_p2;

  assign occ_m1 = occ - CNT_W'(1);
  assign idx_p1 = idx + CNT_W'(1);
  assign idx_p2 = idx + CNT_W'(2);

  assign req.ready  = (state == S_IDLE);
  assign stat.busy  = (state != S_IDLE);
  assign stat.count = occ;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    head       <= head_next;
    tail       <= tail_next;
    prev       <= prev_next;
    key        <= key_next;
    res_status <= res_status_next;
  end

  // Next state, memory requests and offered result
  always_comb begin
    state_next      = state;
    occ_next        = occ;
    idx_next        = idx;
    head_next       = head;
    tail_next       = tail;
    prev_next       = prev;
    key_next        = key;
    res_status_next = res_status;
    ram_req         = '0;

    emit.valid                   = 1'b0;
    emit.item.status             = res_status;
    emit.item.entry_value        = '0;
    emit.item.first_value        = (occ == '0) ? '0 : head;
    emit.item.last_value         = (occ == '0) ? '0 : tail;
    emit.item.entry_count        = count_field(occ);
    emit.item.last_of_run        = 1'b1;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          key_next = req.item.value;
          idx_next = '0;
          case (req.item.opcode)
            OP_APPEND: begin
              if (occ == CAP_CNT) begin
                res_status_next = STS_FULL;
              end else begin
                ram_req.we      = 1'b1;
                ram_req.waddr   = occ[IDX_W-1:0];
                ram_req.wdata   = req.item.value;
                if (occ == '0) begin
                  head_next = req.item.value;
                end
                tail_next       = req.item.value;
                occ_next        = occ + CNT_W'(1);
                res_status_next = STS_OK;
              end
              state_next = S_RESULT;
            end
            OP_REMOVE, OP_LIST: begin
              if (occ == '0) begin
                res_status_next = STS_EMPTY;
                state_next      = S_RESULT;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = '0;
                state_next    = (req.item.opcode == OP_LIST) ? S_LIST : S_SEARCH;
              end
            end
            default: begin
              res_status_next = STS_OK;
              state_next      = S_RESULT;
            end
          endcase
        end
      end

      // One entry compared per cycle
      S_SEARCH: begin
        if (rdata == key) begin
          if (idx == occ_m1) begin
            // match at the tail: no shift, previous entry becomes tail
            occ_next        = occ_m1;
            tail_next       = prev;
            res_status_next = STS_OK;
            state_next      = S_RESULT;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = idx_p1[IDX_W-1:0];
            state_next    = S_SHIFT;
          end
        end else if (idx == occ_m1) begin
          res_status_next = STS_NOTFOUND;
          state_next      = S_RESULT;
        end else begin
          prev_next     = rdata;
          idx_next      = idx_p1;
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_p1[IDX_W-1:0];
        end
      end

      // rdata holds entry idx+1, written back one place lower
      S_SHIFT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx[IDX_W-1:0];
        ram_req.wdata = rdata;
        if (idx == '0) begin
          head_next = rdata;
        end
        if (idx_p1 == occ_m1) begin
          occ_next        = occ_m1;
          res_status_next = STS_OK;
          state_next      = S_RESULT;
        end else begin
          idx_next      = idx_p1;
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_p2[IDX_W-1:0];
        end
      end

      // One entry offered per cycle while the output slot is free, next read issued on transfer
      S_LIST: begin
        emit.valid            = 1'b1;
        emit.item.status      = STS_OK;
        emit.item.entry_value = rdata;
        emit.item.last_of_run = (idx == occ_m1);
        if (slot_free) begin
          if (idx == occ_m1) begin
            state_next = S_IDLE;
          end else begin
            idx_next      = idx_p1;
            ram_req.re    = 1'b1;
            ram_req.raddr = idx_p1[IDX_W-1:0];
          end
        end
      end

      S_RESULT: begin
        emit.valid = 1'b1;
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ordered_list_append_remove_top.sv =====
// Ordered list of up to CAPACITY signed 32-bit values in insertion order,
// held in a one-port-write, one-port-read synchronous RAM. One request is
// worked on at a time; the request side is ready again as soon as the last
// result has moved into the output register. Append, an unknown opcode, and
// any request on an empty list go straight to the result state. Remove reads
// the entries in order up to the match (or up to the last entry when absent),
// then shifts each later entry down one place; RAM read data is registered
// and the compare/shift loop handles one entry per cycle. A list request
// reads the first entry, then gives one result per cycle, slowed only by
// back-pressure on the result side. No clearing pass is needed after reset:
// entries at or beyond the count are never read.
// Depends on olar_pkg, olar_if, olar_ram, olar_seq and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module ordered_list_append_remove_top (
  input  logic       clk,
  input  logic       rst,
  olar_in_if.sink    req,
  olar_out_if.source rsp
);
  import olar_pkg::*;

  ram_req_t  ram_req;
  emit_t     emit;
  seq_stat_t stat;
  data_t     rdata;
  logic      slot_free;
  logic      out_valid;
  out_item_t out_item;
  logic      req_xfer;
  logic      mid_run;

  olar_ram #(
    .DEPTH  (CAPACITY),
    .WIDTH  (DATA_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  olar_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rdata     (rdata),
    .slot_free (slot_free),
    .ram_req   (ram_req),
    .emit      (emit),
    .stat      (stat)
  );

  // Output register: free when empty or being taken this cycle
  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit.valid) begin
      out_item <= emit.item;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.item  = out_item;

  // Checks
  assign req_xfer = req.valid && req.ready;
  assign mid_run  = rsp.valid && !rsp.item.last_of_run;

  `ASSERT_ALWAYS(a_count_bound, clk, rst, stat.count <= CAP_CNT, "count above capacity")
  `ASSERT_NEXT(a_busy_after_transfer, clk, rst, req_xfer, stat.busy, "idle after transfer")
  `ASSERT_IMPLIES(a_mid_run_ok, clk, rst, mid_run, rsp.item.status == STS_OK, "bad mid-run status")

endmodule

`default_nettype wire
